>>> rtl/core/mtb_pkg.sv
// shared types and constants for the millisecond timer bank
`timescale 1ns / 1ps

package mtb_pkg;

    localparam int TIME_W  = 32;
    localparam int INDEX_W = 5;

    // request commands
    localparam logic CMD_START_QUERY = 1'b0;
    localparam logic CMD_DISARM      = 1'b1;

    typedef struct packed {
        logic               command;
        logic [INDEX_W-1:0] timer_index;
        logic [TIME_W-1:0]  duration_ms;
        logic [TIME_W-1:0]  now_ms;
    } t_request;

    // one timer's stored state as seen by the evaluation logic
    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] start_time;
        logic [TIME_W-1:0] timeout_length;
    } t_entry;

    // state change requested by the evaluation logic
    typedef struct packed {
        logic               arm;
        logic               disarm;
        logic [INDEX_W-1:0] timer_index;
        logic [TIME_W-1:0]  duration_ms;
        logic [TIME_W-1:0]  now_ms;
    } t_update;

endpackage

>>> rtl/core/mtb_timer_store.sv
// per-timer running flags, start times and timeout lengths
`timescale 1ns / 1ps

module mtb_timer_store #(
    parameter int NUM_TIMERS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [mtb_pkg::INDEX_W-1:0]  i_rd_index,
    output mtb_pkg::t_entry              o_entry,
    input  logic                         i_we,
    input  mtb_pkg::t_update             i_update
);

    localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    logic [NUM_TIMERS-1:0]           r_running;
    logic [mtb_pkg::TIME_W-1:0]      r_start_time     [NUM_TIMERS];
    logic [mtb_pkg::TIME_W-1:0]      r_timeout_length [NUM_TIMERS];

    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] wr_idx;

    assign rd_idx = i_rd_index[IDX_W-1:0];
    assign wr_idx = i_update.timer_index[IDX_W-1:0];

    // reads of an out-of-range index are masked by the evaluation logic
    always_comb begin
        o_entry.running        = r_running[rd_idx];
        o_entry.start_time     = r_start_time[rd_idx];
        o_entry.timeout_length = r_timeout_length[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= '0;
        end else if (i_we) begin
            if (i_update.arm) begin
                r_running[wr_idx] <= 1'b1;
            end else if (i_update.disarm) begin
                r_running[wr_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we && i_update.arm) begin
            r_start_time[wr_idx]     <= i_update.now_ms;
            r_timeout_length[wr_idx] <= i_update.duration_ms;
        end
    end

endmodule

>>> rtl/core/mtb_expiry.sv
// decides expiry for one request and the state change it causes
`timescale 1ns / 1ps

module mtb_expiry #(
    parameter int NUM_TIMERS = 20
) (
    input  mtb_pkg::t_request  i_req,
    input  mtb_pkg::t_entry    i_entry,
    output mtb_pkg::t_update   o_update,
    output logic               o_expired
);

    localparam logic [mtb_pkg::INDEX_W:0] COUNT = (mtb_pkg::INDEX_W + 1)'(NUM_TIMERS);

    logic                        index_ok;
    logic [mtb_pkg::TIME_W:0]    since_start;
    logic [mtb_pkg::TIME_W-1:0]  elapsed;
    logic [mtb_pkg::TIME_W-1:0]  to_go;
    logic                        timed_out;

    assign index_ok = {1'b0, i_req.timer_index} < COUNT;

    // borrow out of now - start flags a wrapped clock, elapsed counts as zero
    assign since_start = {1'b0, i_req.now_ms} - {1'b0, i_entry.start_time};
    assign elapsed     = since_start[mtb_pkg::TIME_W] ? '0
                                                      : since_start[mtb_pkg::TIME_W-1:0];
    assign to_go       = i_entry.timeout_length - elapsed;
    assign timed_out   = (to_go == '0) || to_go[mtb_pkg::TIME_W-1];

    always_comb begin
        o_update.arm         = 1'b0;
        o_update.disarm      = 1'b0;
        o_update.timer_index = i_req.timer_index;
        o_update.duration_ms = i_req.duration_ms;
        o_update.now_ms      = i_req.now_ms;
        o_expired            = 1'b1;
        if (index_ok) begin
            unique case (i_req.command)
                mtb_pkg::CMD_DISARM: begin
                    o_update.disarm = 1'b1;
                    o_expired       = 1'b0;
                end
                mtb_pkg::CMD_START_QUERY: begin
                    if (i_entry.running) begin
                        o_expired = timed_out;
                    end else begin
                        o_update.arm = 1'b1;
                        o_expired    = 1'b0;
                    end
                end
                default: begin
                    o_expired = 1'b1;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/millisecond_timer_bank_top.sv
// a request waits in the request register until the result register is free
// one request per cycle unless stalled; each reads and may update one timer entry
// the entry read, subtracts and compare sit between the request and result registers
// reset clears the running flags and both valid flags; start times and lengths
// are not cleared and are only read for a running timer
`timescale 1ns / 1ps

module millisecond_timer_bank_top #(
    parameter int NUM_TIMERS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_command,
    input  logic [mtb_pkg::INDEX_W-1:0]  i_timer_index,
    input  logic [mtb_pkg::TIME_W-1:0]   i_duration_ms,
    input  logic [mtb_pkg::TIME_W-1:0]   i_now_ms,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_expired
);

    logic               r_in_valid;
    mtb_pkg::t_request  r_req;
    logic               r_out_valid;
    logic               r_expired;

    logic               out_free;
    logic               advance;
    logic               in_xfer;
    mtb_pkg::t_entry    entry;
    mtb_pkg::t_update   update;
    logic               expired;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    mtb_timer_store #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_index (r_req.timer_index),
        .o_entry    (entry),
        .i_we       (advance),
        .i_update   (update)
    );

    mtb_expiry #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_expiry (
        .i_req     (r_req),
        .i_entry   (entry),
        .o_update  (update),
        .o_expired (expired)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_req.command     <= i_command;
            r_req.timer_index <= i_timer_index;
            r_req.duration_ms <= i_duration_ms;
            r_req.now_ms      <= i_now_ms;
        end
        if (advance) begin
            r_expired <= expired;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_expired   = r_expired;

endmodule

>>> verif/mtb_checker.sv
// scoreboard for the millisecond timer bank: predicts the expired flag and compares results
`timescale 1ns / 1ps

module mtb_checker #(
    parameter int NUM_TIMERS = 20
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    input  logic                         i_in_stall,
    input  logic                         i_command,
    input  logic [mtb_pkg::INDEX_W-1:0]  i_timer_index,
    input  logic [mtb_pkg::TIME_W-1:0]   i_duration_ms,
    input  logic [mtb_pkg::TIME_W-1:0]   i_now_ms,
    input  logic                         i_out_valid,
    input  logic                         i_out_stall,
    input  logic                         i_expired,
    output int                           o_fail_count,
    output int                           o_pending,
    output int                           o_checked,
    output int                           o_expired_seen
);

    logic                       timer_armed [NUM_TIMERS];
    logic [mtb_pkg::TIME_W-1:0] timer_start [NUM_TIMERS];
    logic [mtb_pkg::TIME_W-1:0] timer_len   [NUM_TIMERS];
    logic                       expired_q   [$];

    int fail_cnt    = 0;
    int pending_cnt = 0;
    int checked_cnt = 0;
    int expired_cnt = 0;

    assign o_fail_count   = fail_cnt;
    assign o_pending      = pending_cnt;
    assign o_checked      = checked_cnt;
    assign o_expired_seen = expired_cnt;

    // applies one request to the timer copy and returns the expired flag it answers
    function automatic logic timer_expired(input logic cmd,
                                           input logic [mtb_pkg::INDEX_W-1:0] idx,
                                           input logic [mtb_pkg::TIME_W-1:0] dur,
                                           input logic [mtb_pkg::TIME_W-1:0] now);
        logic [mtb_pkg::TIME_W-1:0] t;
        logic [mtb_pkg::TIME_W-1:0] to_go;
        if (idx >= NUM_TIMERS) return 1'b1;
        if (cmd == mtb_pkg::CMD_DISARM) begin
            timer_armed[idx] = 1'b0;
            return 1'b0;
        end
        if (!timer_armed[idx]) begin
            timer_armed[idx] = 1'b1;
            timer_start[idx] = now;
            timer_len[idx]   = dur;
            return 1'b0;
        end
        // clock wrapped since arming: nothing has elapsed yet
        t     = (now < timer_start[idx]) ? timer_start[idx] : now;
        to_go = timer_len[idx] - (t - timer_start[idx]);
        return (to_go == '0) || to_go[mtb_pkg::TIME_W-1];
    endfunction

    always @(posedge i_clk) begin
        logic want;
        if (!i_rst_n) begin
            foreach (timer_armed[i]) timer_armed[i] = 1'b0;
            expired_q.delete();
            pending_cnt <= 0;
        end else begin
            // retire before accepting so a result arriving alongside its own request is still flagged
            if (i_out_valid && !i_out_stall) begin
                if (expired_q.size() == 0) begin
                    if (fail_cnt < 10)
                        $display("unexpected result transfer: expired=%0b", i_expired);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    want = expired_q.pop_front();
                    checked_cnt <= checked_cnt + 1;
                    if (want) expired_cnt <= expired_cnt + 1;
                    if (i_expired !== want) begin
                        if (fail_cnt < 10)
                            $display("mismatch on result %0d: expired expected %0b, got %0b",
                                     checked_cnt, want, i_expired);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expired_q.push_back(timer_expired(i_command, i_timer_index,
                                                  i_duration_ms, i_now_ms));
            pending_cnt <= expired_q.size();
        end
    end

endmodule

>>> verif/tb_top.sv
// testbench top for the millisecond timer bank: clock, reset, request stimulus and verdict
`timescale 1ns / 1ps

module tb_top;

    localparam int NUM_TIMERS = 20;
    localparam int RAND_ITEMS = 450;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_command;
    logic [mtb_pkg::INDEX_W-1:0] i_timer_index;
    logic [mtb_pkg::TIME_W-1:0]  i_duration_ms;
    logic [mtb_pkg::TIME_W-1:0]  i_now_ms;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic                        o_expired;

    int fail_count;
    int pending;
    int checked;
    int expired_seen;

    int sent_count     = 0;
    int directed_count = 0;
    bit no_idle        = 1'b0;

    // stimulus-side view of which timers are armed, used to aim queries at the deadline
    bit                         stim_armed [NUM_TIMERS];
    logic [mtb_pkg::TIME_W-1:0] stim_start [NUM_TIMERS];
    logic [mtb_pkg::TIME_W-1:0] stim_len   [NUM_TIMERS];

    millisecond_timer_bank_top #(
        .NUM_TIMERS(NUM_TIMERS)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_command    (i_command),
        .i_timer_index(i_timer_index),
        .i_duration_ms(i_duration_ms),
        .i_now_ms     (i_now_ms),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_expired    (o_expired)
    );

    mtb_checker #(
        .NUM_TIMERS(NUM_TIMERS)
    ) u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_timer_index (i_timer_index),
        .i_duration_ms (i_duration_ms),
        .i_now_ms      (i_now_ms),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_expired     (o_expired),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_expired_seen(expired_seen)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end

    // mostly no gap, some short ones, a few long
    function automatic int gap_len();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    initial begin
        int n;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            n = gap_len();
            if (n != 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
    end

    task automatic send_request(input logic cmd, input logic [mtb_pkg::INDEX_W-1:0] idx,
                                input logic [mtb_pkg::TIME_W-1:0] dur,
                                input logic [mtb_pkg::TIME_W-1:0] now);
        int n;
        n = gap_len();
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_command     <= cmd;
        i_timer_index <= idx;
        i_duration_ms <= dur;
        i_now_ms      <= now;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
        if (idx < NUM_TIMERS) begin
            if (cmd == mtb_pkg::CMD_DISARM) begin
                stim_armed[idx] = 1'b0;
            end else if (!stim_armed[idx]) begin
                stim_armed[idx] = 1'b1;
                stim_start[idx] = now;
                stim_len[idx]   = dur;
            end
        end
    endtask

    // hold off new requests until every outstanding result has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    initial begin
        int                          r;
        logic                        cmd;
        logic [mtb_pkg::INDEX_W-1:0] idx;
        logic [mtb_pkg::TIME_W-1:0]  dur;
        logic [mtb_pkg::TIME_W-1:0]  now;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_command     <= mtb_pkg::CMD_START_QUERY;
        i_timer_index <= '0;
        i_duration_ms <= '0;
        i_now_ms      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // out of range indices, both commands
        send_request(mtb_pkg::CMD_START_QUERY, 5'd20, 32'd0, 32'd0);
        send_request(mtb_pkg::CMD_DISARM, 5'd31, '1, '1);
        // zero duration on the highest timer expires at once
        send_request(mtb_pkg::CMD_START_QUERY, 5'd19, 32'd0, 32'd0);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd19, '1, 32'd0);
        // all-ones duration reads as negative, and the clock wraps below the start
        send_request(mtb_pkg::CMD_START_QUERY, 5'd0, '1, '1);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd0, 32'd0, 32'd0);
        // one before the deadline, at it, and before the start
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, 32'd100, 32'd1000);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, 32'd0, 32'd1099);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, 32'd0, 32'd1100);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, 32'd0, 32'd999);
        // largest positive remaining time, then crossing the sign boundary
        send_request(mtb_pkg::CMD_START_QUERY, 5'd2, 32'h7FFF_FFFF, 32'd5);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd2, 32'd0, 32'd5);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd2, 32'd0, '1);
        // disarm an armed and an idle timer, then rearm
        send_request(mtb_pkg::CMD_DISARM, 5'd1, 32'd0, 32'd0);
        send_request(mtb_pkg::CMD_DISARM, 5'd3, '1, 32'd0);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, 32'd7, 32'd40);
        // duration on a query is ignored
        send_request(mtb_pkg::CMD_START_QUERY, 5'd1, '1, 32'd47);
        send_request(mtb_pkg::CMD_DISARM, 5'd19, 32'd0, 32'd0);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd4, 32'h8000_0000, 32'd0);
        send_request(mtb_pkg::CMD_START_QUERY, 5'd4, 32'd0, 32'd0);
        directed_count = sent_count;
        drain_results();

        for (int k = 0; k < RAND_ITEMS; k++) begin
            no_idle = (k >= 200 && k < 280);
            if (k % 150 == 149) drain_results();
            r   = $urandom_range(0, 99);
            idx = (mtb_pkg::INDEX_W)'($urandom_range(0, NUM_TIMERS - 1));
            cmd = mtb_pkg::CMD_START_QUERY;
            dur = $urandom;
            now = $urandom;
            if (r < 8) begin
                idx = (mtb_pkg::INDEX_W)'($urandom_range(NUM_TIMERS, 31));
                cmd = 1'($urandom_range(0, 1));
            end else if (r < 22) begin
                cmd = mtb_pkg::CMD_DISARM;
            end else if (!stim_armed[idx]) begin
                case ($urandom_range(0, 4))
                    0:       dur = $urandom_range(0, 50);
                    1:       dur = 32'h8000_0000 + $urandom_range(0, 32) - 16;
                    2:       dur = $urandom_range(0, 1) ? '0 : '1;
                    3:       dur = $urandom_range(51, 100000);
                    default: ;
                endcase
                if ($urandom_range(0, 3) == 0) now = 32'hFFFF_FFFF - $urandom_range(0, 200);
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: now = stim_start[idx] + stim_len[idx] + $urandom_range(0, 4) - 2;
                    4, 5:       now = stim_start[idx] - $urandom_range(1, 1000);
                    6, 7:       now = stim_start[idx] + $urandom_range(0, 1000);
                    default:    ;
                endcase
            end
            send_request(cmd, idx, dur, now);
        end
        no_idle = 1'b0;

        i_in_valid <= 1'b0;
        for (int c = 0; c < 5000 && pending != 0; c++) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests (%0d directed, rest random with deadline-aimed queries)",
                 sent_count, directed_count);
        $display("%0d results checked, %0d of them expired, %0d still outstanding",
                 checked, expired_seen, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
